### hdl/pmr_pkg.sv
// Shared types, constants and helpers for the packed message renderer.
`default_nettype none
package pmr_pkg;
	localparam int HEADER_BYTES = 14;
	localparam int COUNT_BITS = 32;
	localparam int CMP_BITS = (COUNT_BITS > 32) ? COUNT_BITS : 32;
	localparam int HDR_BITS = 4;
	localparam int FIELD_BITS = 3;
	localparam int FIELDS = 5;
	localparam int LABELLED = 4;
	localparam int LABEL_LEN = 10;
	localparam int MAX_PUSH = 12;
	localparam int STEP_BITS = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = 2;
	localparam int QCNT_BITS = 3;
	localparam int CFG_INDEX_BITS = 1;

	localparam logic [7:0] LINE_END = 8'h0d;

	localparam logic [CFG_INDEX_BITS-1:0] REG_RENDER_MODE = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_OUTPUT_LIMIT = 1'd1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_TRUNC = 2'd1;
	localparam logic [1:0] ST_TRAIL = 2'd2;
	localparam logic [1:0] ST_OVER = 2'd3;

	localparam logic [3:0][79:0] LABEL_TEXT = {
		"Subject = ", "From    = ", "To      = ", "Date    = "
	};

	typedef logic [COUNT_BITS-1:0] count_t;

	typedef struct packed {
		logic label_en;
		logic [1:0] label_sel;
		logic [7:0] data;
		logic [1:0] data_n;
		logic sum_en;
		logic sum_final;
		logic last;
		count_t taken;
	} cmd_t;

	function automatic count_t sat_inc(input count_t v);
		return (v == {COUNT_BITS{1'b1}}) ? v : v + count_t'(1);
	endfunction

	function automatic logic [CMP_BITS-1:0] cmp_ext(input count_t v);
		return CMP_BITS'(v);
	endfunction

	function automatic logic [7:0] label_char(input logic [1:0] sel,
			input logic [STEP_BITS-1:0] k);
		logic [79:0] t;
		int pos;
		t = LABEL_TEXT[sel];
		pos = 8 * (LABEL_LEN - 1 - int'(k));
		if (int'(k) >= LABEL_LEN)
			return 8'h00;
		return t[pos +: 8];
	endfunction
endpackage
`default_nettype wire

### hdl/pmr_queue.sv
// Short command queue between the front parser and the back renderer.
`default_nettype none
module pmr_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire pmr_pkg::cmd_t push_data,
	output logic full,
	input wire logic pop,
	output logic head_valid,
	output pmr_pkg::cmd_t head_data
);
	pmr_pkg::cmd_t mem_q [pmr_pkg::QUEUE_DEPTH];
	logic [pmr_pkg::QPTR_BITS-1:0] wr_ptr_q;
	logic [pmr_pkg::QPTR_BITS-1:0] rd_ptr_q;
	logic [pmr_pkg::QCNT_BITS-1:0] count_q;
	logic do_pop;

	assign full = (count_q == pmr_pkg::QCNT_BITS'(pmr_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data = mem_q[rd_ptr_q];
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push && !full)
				wr_ptr_q <= wr_ptr_q + pmr_pkg::QPTR_BITS'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + pmr_pkg::QPTR_BITS'(1);
			if ((push && !full) && !do_pop)
				count_q <= count_q + pmr_pkg::QCNT_BITS'(1);
			else if (!(push && !full) && do_pop)
				count_q <= count_q - pmr_pkg::QCNT_BITS'(1);
		end
	end
endmodule
`default_nettype wire

### hdl/pmr_front.sv
// Front parser: walks header and fields, turns each field byte into a render command.
`default_nettype none
module pmr_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic render_mode,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] in_byte,
	input wire logic in_last,
	input wire logic q_full,
	output logic q_push,
	output pmr_pkg::cmd_t q_data
);
	logic [pmr_pkg::HDR_BITS-1:0] hdr_left_q;
	logic [pmr_pkg::FIELD_BITS-1:0] field_q;
	logic started_q;
	pmr_pkg::count_t taken_q;
	logic drain_q;

	logic accept;
	logic need;
	logic restart;
	logic go_drain;
	pmr_pkg::count_t taken_next;
	pmr_pkg::cmd_t cmd;

	assign in_stall = q_full;
	assign accept = in_valid && !q_full;
	assign taken_next = pmr_pkg::sat_inc(taken_q);

	always_comb begin
		cmd = '0;
		cmd.label_sel = field_q[1:0];
		cmd.last = in_last;
		cmd.taken = taken_next;
		restart = 1'b0;
		go_drain = 1'b0;
		if (!drain_q && hdr_left_q == '0) begin
			cmd.label_en = (field_q < pmr_pkg::FIELD_BITS'(pmr_pkg::LABELLED)) && !started_q;
			if (in_byte != 8'h00) begin
				cmd.data = in_byte;
				cmd.data_n = 2'd1;
			end else begin
				cmd.data = pmr_pkg::LINE_END;
				cmd.data_n = (field_q == pmr_pkg::FIELD_BITS'(pmr_pkg::LABELLED - 1)) ?
					2'd2 : 2'd1;
				if (field_q == pmr_pkg::FIELD_BITS'(pmr_pkg::FIELDS - 1)) begin
					cmd.sum_en = 1'b1;
					cmd.sum_final = 1'b1;
					restart = 1'b1;
					go_drain = render_mode && !in_last;
				end
			end
		end
		if (!drain_q && !cmd.sum_final && in_last) begin
			cmd.sum_en = 1'b1;
			restart = 1'b1;
		end
		if (drain_q && in_last)
			restart = 1'b1;
		need = !drain_q && (cmd.label_en || cmd.data_n != 2'd0 || cmd.sum_en);
	end

	assign q_push = accept && need;
	assign q_data = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_left_q <= pmr_pkg::HDR_BITS'(pmr_pkg::HEADER_BYTES);
			field_q <= '0;
			started_q <= 1'b0;
			taken_q <= '0;
			drain_q <= 1'b0;
		end else if (accept) begin
			if (restart) begin
				hdr_left_q <= pmr_pkg::HDR_BITS'(pmr_pkg::HEADER_BYTES);
				field_q <= '0;
				started_q <= 1'b0;
				taken_q <= '0;
				drain_q <= go_drain;
			end else if (!drain_q) begin
				taken_q <= taken_next;
				if (hdr_left_q != '0) begin
					hdr_left_q <= hdr_left_q - pmr_pkg::HDR_BITS'(1);
				end else if (in_byte != 8'h00) begin
					started_q <= 1'b1;
				end else begin
					field_q <= field_q + pmr_pkg::FIELD_BITS'(1);
					started_q <= 1'b0;
				end
			end
		end
	end
endmodule
`default_nettype wire

### hdl/pmr_back.sv
// Back renderer: expands commands into rendered bytes and record summaries.
`default_nettype none
module pmr_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic render_mode,
	input wire logic [31:0] output_limit,
	input wire logic q_valid,
	input wire pmr_pkg::cmd_t q_data,
	output logic q_pop,
	output logic out_valid,
	input wire logic out_stall,
	output logic [7:0] out_byte,
	output logic item_kind,
	output logic [1:0] status,
	output logic [31:0] consumed_count,
	output logic [31:0] produced_count,
	output logic out_last
);
	logic [pmr_pkg::STEP_BITS-1:0] step_q;
	logic [pmr_pkg::STEP_BITS-1:0] push_cnt_q;
	pmr_pkg::count_t rendered_q;
	logic overflow_q;
	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic kind_q;
	logic [1:0] status_q;
	logic [31:0] consumed_q;
	logic [31:0] produced_q;

	logic [pmr_pkg::STEP_BITS-1:0] lab_len;
	logic [pmr_pkg::STEP_BITS-1:0] data_end;
	logic [pmr_pkg::STEP_BITS-1:0] total;
	logic is_label;
	logic is_data;
	logic is_sum;
	logic last_step;
	logic advance;
	logic over;
	logic emit;
	logic [7:0] step_byte;
	logic [1:0] sum_status;
	pmr_pkg::count_t rend_next;
	logic [pmr_pkg::CMP_BITS-1:0] limit_ext;
	logic [pmr_pkg::CMP_BITS-1:0] taken_ext;
	logic [pmr_pkg::CMP_BITS-1:0] rendered_ext;

	assign limit_ext = pmr_pkg::CMP_BITS'(output_limit);
	assign taken_ext = pmr_pkg::cmp_ext(q_data.taken);
	assign rendered_ext = pmr_pkg::cmp_ext(rendered_q);
	assign lab_len = q_data.label_en ? pmr_pkg::STEP_BITS'(pmr_pkg::LABEL_LEN) : '0;
	assign data_end = lab_len + pmr_pkg::STEP_BITS'(q_data.data_n);
	assign total = data_end + pmr_pkg::STEP_BITS'(q_data.sum_en);
	assign is_label = step_q < lab_len;
	assign is_data = !is_label && (step_q < data_end);
	assign is_sum = !is_label && !is_data;
	assign last_step = (step_q == total - pmr_pkg::STEP_BITS'(1));
	assign advance = q_valid && (!out_valid_q || !out_stall);
	assign q_pop = advance && last_step;

	assign rend_next = pmr_pkg::sat_inc(rendered_q);
	assign over = pmr_pkg::cmp_ext(rend_next) > limit_ext;
	assign step_byte = is_label ? pmr_pkg::label_char(q_data.label_sel, step_q) : q_data.data;

	always_comb begin
		if (!q_data.sum_final)
			sum_status = pmr_pkg::ST_TRUNC;
		else if (render_mode && !q_data.last)
			sum_status = pmr_pkg::ST_TRAIL;
		else if (render_mode && (overflow_q || rendered_ext > limit_ext))
			sum_status = pmr_pkg::ST_OVER;
		else
			sum_status = pmr_pkg::ST_OK;
	end

	assign emit = (is_sum || (render_mode && !over)) &&
		(push_cnt_q < pmr_pkg::STEP_BITS'(pmr_pkg::MAX_PUSH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			push_cnt_q <= '0;
			rendered_q <= '0;
			overflow_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance && emit)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (advance) begin
				if (last_step) begin
					step_q <= '0;
					push_cnt_q <= '0;
				end else begin
					step_q <= step_q + pmr_pkg::STEP_BITS'(1);
					if (emit)
						push_cnt_q <= push_cnt_q + pmr_pkg::STEP_BITS'(1);
				end
				if (is_sum) begin
					rendered_q <= '0;
					overflow_q <= 1'b0;
				end else begin
					rendered_q <= rend_next;
					if (render_mode && over)
						overflow_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			if (is_sum) begin
				out_byte_q <= 8'h00;
				kind_q <= 1'b1;
				status_q <= sum_status;
				consumed_q <= q_data.sum_final ? taken_ext[31:0] : '0;
				produced_q <= q_data.sum_final ? rendered_ext[31:0] : '0;
			end else begin
				out_byte_q <= step_byte;
				kind_q <= 1'b0;
				status_q <= pmr_pkg::ST_OK;
				consumed_q <= '0;
				produced_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign item_kind = kind_q;
	assign status = status_q;
	assign consumed_count = consumed_q;
	assign produced_count = produced_q;
	assign out_last = kind_q;
endmodule
`default_nettype wire

### hdl/packed_message_renderer_unit.sv
// Packed message renderer top level: config registers, front parser, queue, back renderer.
// A result passes through the command queue and then the output register.
// Throughput: one input byte per cycle, while the queue has room, when each makes at most
// one result; the back sequencer issues one step per cycle, one per label character and byte.
// The four-entry command queue absorbs those bursts; output stall holds the back sequencer.
// Reset: record walk restarts at the header, render_mode = 0, output_limit = all ones.
`default_nettype none
module packed_message_renderer_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] in_byte,
	input wire logic in_last,
	output logic out_valid,
	input wire logic out_stall,
	output logic [7:0] out_byte,
	output logic item_kind,
	output logic [1:0] status,
	output logic [31:0] consumed_count,
	output logic [31:0] produced_count,
	output logic out_last,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [pmr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	logic render_mode_q;
	logic [31:0] output_limit_q;
	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_valid;
	pmr_pkg::cmd_t q_wdata;
	pmr_pkg::cmd_t q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			render_mode_q <= 1'b0;
			output_limit_q <= 32'hffff_ffff;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pmr_pkg::REG_RENDER_MODE: render_mode_q <= cfg_data[0];
				pmr_pkg::REG_OUTPUT_LIMIT: output_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pmr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.render_mode(render_mode_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.in_last(in_last),
		.q_full(q_full),
		.q_push(q_push),
		.q_data(q_wdata)
	);

	pmr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(q_wdata),
		.full(q_full),
		.pop(q_pop),
		.head_valid(q_valid),
		.head_data(q_head)
	);

	pmr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.render_mode(render_mode_q),
		.output_limit(output_limit_q),
		.q_valid(q_valid),
		.q_data(q_head),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.item_kind(item_kind),
		.status(status),
		.consumed_count(consumed_count),
		.produced_count(produced_count),
		.out_last(out_last)
	);
endmodule
`default_nettype wire
